// File: hdl/vertical_aspect_scaler_5_to_6_unit_defines.svh
// Assertion macros used by the vertical aspect scaler back module.
`ifndef VERTICAL_ASPECT_SCALER_5_TO_6_UNIT_DEFINES_SVH
`define VERTICAL_ASPECT_SCALER_5_TO_6_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on aclk and masked during reset.
`define VAS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and masked during reset.
`define VAS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/vas_pkg.sv
// Shared types and constants for the vertical aspect scaler.
`timescale 1ns / 1ps

package vas_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FORMAT_565  = 2'd0;
    localparam logic [1:0] CFG_LINE_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_GROUP_COUNT = 2'd2;

    // Configuration reset values.
    localparam logic        FORMAT_565_RESET  = 1'b1;
    localparam logic [10:0] LINE_WIDTH_RESET  = 11'd320;
    localparam logic [8:0]  GROUP_COUNT_RESET = 9'd48;
    localparam logic [8:0]  GROUP_COUNT_MAX   = 9'd256;

    // Channel masks for the two pixel formats.
    localparam logic [15:0] RB_MASK_555 = 16'h7C1F;
    localparam logic [15:0] RB_MASK_565 = 16'hF81F;
    localparam logic [15:0] G_MASK_555  = 16'h03E0;
    localparam logic [15:0] G_MASK_565  = 16'h07E0;

    // Row codes within an input group and an output group.
    localparam logic [2:0] ROW_TOP     = 3'd0;
    localparam logic [2:0] ROW_BLEND_1 = 3'd1;
    localparam logic [2:0] ROW_BLEND_2 = 3'd2;
    localparam logic [2:0] ROW_BLEND_3 = 3'd3;
    localparam logic [2:0] ROW_LAST_IN = 3'd4;
    localparam logic [2:0] ROW_BOTTOM  = 3'd5;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // One classified input item, as passed from the front to the back.
    typedef struct packed {
        logic [15:0] pixel;
        logic [15:0] upper;
        logic [2:0]  phase;
        logic [9:0]  column;
        logic        frame_end;
    } vas_entry_t;

endpackage

// File: hdl/vertical_aspect_scaler_5_to_6_unit.sv
// Vertical 5-to-6 aspect scaler for 16-bit RGB pixels.
// Pixels arrive in raster order in groups of five rows and leave as six rows per group:
// output row 0 copies input row 0, rows 1 to 4 blend adjacent input rows, and row 5
// copies input row 4. The result port issues one result per cycle while m_ready holds, so
// an input in rows 0 to 3 yields one result and an input in row 4 yields two; the single
// output register sets that pace, and a four-entry queue lets the input keep flowing while
// a row-4 item emits its two results. The first result of an input passes through the
// stage register and line buffer read register, the queue slot and the blend into the
// output register. The line buffer is a LINE_MAX-deep memory with one read and one write
// per input, needs no clearing pass after reset, and is valid once the first row of a
// frame has been written. Configuration writes are accepted on every cycle and must only
// be made while the block is idle.
`timescale 1ns / 1ps

module vertical_aspect_scaler_5_to_6_unit #(
    parameter int LINE_MAX = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_in_pixel,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_out_pixel,
    output logic [2:0]  m_out_row,
    output logic [9:0]  m_out_column,
    output logic        m_last_of_item,
    output logic        m_frame_done
);
    import vas_pkg::*;

    logic        format_565_reg;
    logic [10:0] line_width_reg;
    logic [8:0]  group_count_reg;

    logic        push_valid;
    logic        push_ready;
    vas_entry_t  push_entry;
    logic        pop_valid;
    logic        pop_ready;
    vas_entry_t  pop_entry;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_565_reg  <= FORMAT_565_RESET;
            line_width_reg  <= LINE_WIDTH_RESET;
            group_count_reg <= GROUP_COUNT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_FORMAT_565:  format_565_reg  <= cfg_data[0];
                CFG_LINE_WIDTH:  line_width_reg  <= cfg_data;
                CFG_GROUP_COUNT: group_count_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    vas_front #(
        .LINE_MAX(LINE_MAX)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .line_width  (line_width_reg),
        .group_count (group_count_reg),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_pixel    (s_in_pixel),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_entry  (push_entry)
    );

    vas_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    vas_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .format_565     (format_565_reg),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_entry      (pop_entry),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_pixel    (m_out_pixel),
        .m_out_row      (m_out_row),
        .m_out_column   (m_out_column),
        .m_last_of_item (m_last_of_item),
        .m_frame_done   (m_frame_done)
    );

endmodule

// File: hdl/vas_queue.sv
// Short first-in first-out queue of classified items between front and back.
`timescale 1ns / 1ps

module vas_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  vas_pkg::vas_entry_t push_entry,
    output logic                pop_valid,
    input  logic                pop_ready,
    output vas_pkg::vas_entry_t pop_entry
);
    import vas_pkg::*;

    vas_entry_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Occupancy follows the push and pop transfers.
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Storage slots carry payload only.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: hdl/vas_front.sv
// Front part: accepts pixels, tracks position in the frame and keeps the line buffer.
`timescale 1ns / 1ps

module vas_front #(
    parameter int LINE_MAX = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [10:0]         line_width,
    input  logic [8:0]          group_count,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [15:0]         in_pixel,
    output logic                push_valid,
    input  logic                push_ready,
    output vas_pkg::vas_entry_t push_entry
);
    import vas_pkg::*;

    localparam int CW = $clog2(LINE_MAX);
    localparam int WW = (CW + 1 > 11) ? CW + 1 : 11;

    // Line buffer holding the previous input row.
    logic [15:0]   line_mem [LINE_MAX];
    logic [15:0]   upper_rd_reg;

    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [2:0]    phase_reg;
    logic [2:0]    phase_next;
    logic [7:0]    group_reg;
    logic [7:0]    group_next;

    logic          s1_valid_reg;
    logic [15:0]   s1_pixel_reg;
    logic [2:0]    s1_phase_reg;
    logic [9:0]    s1_column_reg;
    logic          s1_frame_end_reg;

    logic          in_accept;
    logic [WW-1:0] width_raw;
    logic [WW-1:0] width_eff;
    logic [WW-1:0] col_plus;
    logic [8:0]    groups_eff;
    logic [8:0]    group_plus;
    logic          last_phase;
    logic          row_end;
    logic          frame_end;

    assign in_ready  = !s1_valid_reg || push_ready;
    assign in_accept = in_valid && in_ready;

    // Effective row width and group count, clamped to their legal ranges.
    always_comb begin
        width_raw = WW'(line_width);
        if (width_raw == '0) begin
            width_eff = WW'(1);
        end else if (width_raw > WW'(LINE_MAX)) begin
            width_eff = WW'(LINE_MAX);
        end else begin
            width_eff = width_raw;
        end
        if (group_count == '0) begin
            groups_eff = 9'd1;
        end else if (group_count > GROUP_COUNT_MAX) begin
            groups_eff = GROUP_COUNT_MAX;
        end else begin
            groups_eff = group_count;
        end
    end

    // End of row and end of frame for the current item.
    assign col_plus   = WW'(col_reg) + WW'(1);
    assign group_plus = {1'b0, group_reg} + 9'd1;
    assign last_phase = (phase_reg >= ROW_LAST_IN);
    assign row_end    = (col_plus >= width_eff);
    assign frame_end  = row_end && last_phase && (group_plus >= groups_eff);

    // Position counters advance by one item.
    always_comb begin
        col_next   = col_reg;
        phase_next = phase_reg;
        group_next = group_reg;
        if (row_end) begin
            col_next = '0;
            if (last_phase) begin
                phase_next = ROW_TOP;
                group_next = frame_end ? 8'd0 : group_plus[7:0];
            end else begin
                phase_next = phase_reg + 3'd1;
            end
        end else begin
            col_next = col_plus[CW-1:0];
        end
    end

    // Control state: position counters and the stage register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            phase_reg    <= ROW_TOP;
            group_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (in_accept) begin
                col_reg   <= col_next;
                phase_reg <= phase_next;
                group_reg <= group_next;
            end
            if (in_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (push_ready) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // Stage register payload, loaded with each accepted item.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_pixel_reg     <= in_pixel;
            s1_phase_reg     <= phase_reg;
            s1_column_reg    <= 10'(col_reg);
            s1_frame_end_reg <= frame_end;
        end
    end

    // Line buffer: read the old entry and replace it in the same transfer.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            upper_rd_reg      <= line_mem[col_reg];
            line_mem[col_reg] <= in_pixel;
        end
    end

    assign push_valid           = s1_valid_reg;
    assign push_entry.pixel     = s1_pixel_reg;
    assign push_entry.upper     = upper_rd_reg;
    assign push_entry.phase     = s1_phase_reg;
    assign push_entry.column    = s1_column_reg;
    assign push_entry.frame_end = s1_frame_end_reg;

endmodule

// File: hdl/vas_back.sv
// Back part: blends rows and emits one or two results per item through an output register.
`timescale 1ns / 1ps
`include "vertical_aspect_scaler_5_to_6_unit_defines.svh"

module vas_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                format_565,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  vas_pkg::vas_entry_t pop_entry,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [15:0]         m_out_pixel,
    output logic [2:0]          m_out_row,
    output logic [9:0]          m_out_column,
    output logic                m_last_of_item,
    output logic                m_frame_done
);
    import vas_pkg::*;

    logic        m_valid_reg;
    logic [15:0] pixel_reg;
    logic [2:0]  row_reg;
    logic [9:0]  column_reg;
    logic        last_reg;
    logic        done_reg;

    // Bottom row copy still owed for an item of the last input row.
    logic        pend_reg;
    logic [15:0] pend_pixel_reg;
    logic [9:0]  pend_column_reg;
    logic        pend_done_reg;

    logic        out_free;
    logic        pop;
    logic [15:0] rb_mask;
    logic [15:0] g_mask;
    logic [15:0] blended;
    logic [15:0] result_pixel;

    // Upper weight (x) and lower weight (y) built from truncating shifts.
    function automatic logic [25:0] weigh(input logic [25:0] x, input logic [25:0] y,
                                          input logic [2:0] phase);
        logic [25:0] sum;
        case (phase)
            ROW_BLEND_1: sum = ((x >> 2) - (x >> 4)) + ((y >> 1) + (y >> 2) + (y >> 4));
            ROW_BLEND_2: sum = ((x >> 1) - (x >> 3)) + ((y >> 1) + (y >> 3));
            ROW_BLEND_3: sum = ((x >> 1) + (x >> 3)) + ((y >> 1) - (y >> 3));
            default:     sum = ((x >> 1) + (x >> 2) + (x >> 4)) + ((y >> 2) - (y >> 4));
        endcase
        return sum;
    endfunction

    assign rb_mask = format_565 ? RB_MASK_565 : RB_MASK_555;
    assign g_mask  = format_565 ? G_MASK_565 : G_MASK_555;

    // Red/blue word carries 8 fraction bits, the green word 3.
    always_comb begin
        logic [25:0] rb;
        logic [25:0] g;
        rb = weigh(26'(pop_entry.upper & rb_mask) << 8,
                   26'(pop_entry.pixel & rb_mask) << 8, pop_entry.phase);
        g  = weigh(26'(pop_entry.upper & g_mask) << 3,
                   26'(pop_entry.pixel & g_mask) << 3, pop_entry.phase);
        blended = (16'(rb >> 8) & rb_mask) | (16'(g >> 3) & g_mask);
    end

    assign result_pixel = (pop_entry.phase == ROW_TOP) ? pop_entry.pixel : blended;

    assign out_free  = !m_valid_reg || m_ready;
    assign pop_ready = out_free && !pend_reg;
    assign pop       = pop_valid && pop_ready;

    // Control state of the output register and the pending bottom row.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else if (out_free) begin
            if (pend_reg) begin
                m_valid_reg <= 1'b1;
                pend_reg    <= 1'b0;
            end else begin
                m_valid_reg <= pop_valid;
                pend_reg    <= pop_valid && (pop_entry.phase == ROW_LAST_IN);
            end
        end
    end

    // Output and pending payload.
    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (pend_reg) begin
                pixel_reg  <= pend_pixel_reg;
                row_reg    <= ROW_BOTTOM;
                column_reg <= pend_column_reg;
                last_reg   <= 1'b1;
                done_reg   <= pend_done_reg;
            end else begin
                pixel_reg  <= result_pixel;
                row_reg    <= pop_entry.phase;
                column_reg <= pop_entry.column;
                last_reg   <= (pop_entry.phase != ROW_LAST_IN);
                done_reg   <= 1'b0;
            end
        end
        if (pop) begin
            pend_pixel_reg  <= pop_entry.pixel;
            pend_column_reg <= pop_entry.column;
            pend_done_reg   <= pop_entry.frame_end;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_pixel    = pixel_reg;
    assign m_out_row      = row_reg;
    assign m_out_column   = column_reg;
    assign m_last_of_item = last_reg;
    assign m_frame_done   = done_reg;

    // A taken output for the last input row is followed at once by its bottom row copy.
    `VAS_ASSERT_NXT(a_bottom_follows, m_valid_reg && m_ready && (row_reg == ROW_LAST_IN), m_valid_reg && (row_reg == ROW_BOTTOM), "bottom row copy did not follow")
    // The queue is never read while a bottom row copy is owed.
    `VAS_ASSERT_IMP(a_no_pop_when_pending, pend_reg, !pop, "queue read while bottom row pending")
    // End of frame is flagged only on the final bottom row result.
    `VAS_ASSERT_IMP(a_done_on_bottom, m_valid_reg && done_reg, last_reg && (row_reg == ROW_BOTTOM), "frame end on wrong result")
    // Only the last input row leaves a result that is not the final one of its item.
    `VAS_ASSERT_IMP(a_last_flag, m_valid_reg && !last_reg, row_reg == ROW_LAST_IN, "unexpected non-final result")

endmodule
